FILE: rtl/rcsf_pkg.sv
package rcsf_pkg;

    // operand and result widths of the shared arithmetic unit
    localparam int XW = 68;
    localparam int YW = 34;
    localparam int RW = 96;

    localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_REST_LENGTH  = 3'd0,
        CFG_STIFFNESS    = 3'd1,
        CFG_DAMPING      = 3'd2,
        CFG_MIN_DISTANCE = 3'd3,
        CFG_SEVER_ENABLE = 3'd4,
        CFG_SEVER_TIME   = 3'd5
    } t_cfg_idx;

    localparam logic [31:0] RST_REST_LENGTH  = 32'd65536;
    localparam logic [31:0] RST_STIFFNESS    = 32'd6553600;
    localparam logic [31:0] RST_DAMPING      = 32'd65536;
    localparam logic [31:0] RST_MIN_DISTANCE = 32'd1;
    localparam logic [31:0] RST_SEVER_TIME   = 32'd0;

    typedef struct packed {
        logic [31:0]        time_now;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               is_first;
        logic               is_final;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [30:0]        tension_above;
        logic               top_node;
        logic               end_of_chain;
        logic               severed;
    } t_out;

    typedef struct packed {
        logic [31:0] rest_length;
        logic [31:0] stiffness;
        logic [31:0] damping;
        logic [31:0] min_distance;
        logic        sever_enable;
        logic [31:0] cut_time;
    } t_cfg;

    // shared unit operations
    typedef enum logic [1:0] {
        U_MUL  = 2'd0,
        U_DIV  = 2'd1,
        U_SQRT = 2'd2
    } t_uop;

    typedef struct packed {
        logic            start;
        t_uop            op;
        logic [XW-1:0]   x;
        logic [YW-1:0]   y;
    } t_unit_req;

    typedef struct packed {
        logic            done;
        logic [RW-1:0]   res;
    } t_unit_rsp;

    // saturate a 33-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // magnitude of a 33-bit signed value
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

FILE: rtl/rcsf_unit.sv
module rcsf_unit
    import rcsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic          r_busy;
    logic          r_done;
    t_uop          r_op;
    logic [6:0]    r_cnt;
    logic [RW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [YW:0]   r_rem;
    logic [RW-1:0] r_acc;

    logic [YW:0]   div_trial;
    logic [YW:0]   div_diff;
    logic [YW+2:0] sq_trial;
    logic [YW+2:0] sq_sub;

    // one restoring step for divide and root
    always_comb begin
        div_trial = {r_rem[YW-1:0], r_x[RW-1]};
        div_diff  = div_trial - {1'b0, r_y};
        sq_trial  = {r_rem, r_x[RW-1:RW-2]};
        sq_sub    = {1'b0, r_acc[YW-1:0], 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_y    <= i_req.y;
                r_rem  <= '0;
                r_acc  <= '0;
                unique case (i_req.op)
                    U_MUL: begin
                        r_x   <= RW'(i_req.x);
                        r_cnt <= 7'(YW - 1);
                    end
                    U_DIV: begin
                        r_x   <= {i_req.x, (RW-XW)'(0)};
                        r_cnt <= 7'(XW - 1);
                    end
                    default: begin
                        r_x   <= {i_req.x, (RW-XW)'(0)};
                        r_cnt <= 7'(XW/2 - 1);
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    U_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= r_x << 1;
                        r_y <= r_y >> 1;
                    end
                    U_DIV: begin
                        if (!div_diff[YW]) begin
                            r_rem <= {1'b0, div_diff[YW-1:0]};
                        end else begin
                            r_rem <= {1'b0, div_trial[YW-1:0]};
                        end
                        r_acc <= {r_acc[RW-2:0], ~div_diff[YW]};
                        r_x   <= r_x << 1;
                    end
                    default: begin
                        if (sq_trial >= sq_sub) begin
                            r_rem <= (YW+1)'(sq_trial - sq_sub);
                            r_acc <= {r_acc[RW-2:0], 1'b1};
                        end else begin
                            r_rem <= sq_trial[YW:0];
                            r_acc <= {r_acc[RW-2:0], 1'b0};
                        end
                        r_x <= r_x << 2;
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

FILE: rtl/rcsf_core.sv
module rcsf_core
    import rcsf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in        i_item,
    input  t_cfg       i_cfg,
    output logic       o_busy,
    input  logic       i_room,
    output logic       o_emit,
    output logic [1:0] o_nres,
    output t_out       o_res0,
    output t_out       o_res1,
    output t_unit_req  o_req,
    input  t_unit_rsp  i_rsp
);

    localparam int SAT_SH = 31 + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SQ, S_DT, S_ROOT, S_CHK, S_RATE, S_DAMP,
        S_STIFF, S_TEN, S_FMUL, S_FDIV, S_FIN, S_EMIT
    } t_state;

    t_state r_state;
    t_in    r_item;
    logic   r_sev;
    logic   r_wait;
    logic [1:0] r_c;

    // chain state
    logic [31:0]        r_prev_p [3];
    logic [31:0]        r_prev_v [3];
    logic signed [31:0] r_pend_f [3];
    logic [30:0]        r_pend_ten;
    logic               r_pend_top;
    logic               r_have;

    // segment working registers
    logic signed [32:0] r_dp [3];
    logic signed [32:0] r_dv [3];
    logic [XW-1:0]      r_s;
    logic signed [XW-1:0] r_dot;
    logic [YW-1:0]      r_dist;
    logic [YW-1:0]      r_stretch;
    logic [XW-1:0]      r_rate;
    logic [XW-1:0]      r_num;
    logic [RW-1:0]      r_acc;
    logic               r_tsat;
    logic [30:0]        r_ten;
    logic signed [31:0] r_fup [3];

    logic [1:0] r_nres;
    t_out       r_res0;
    t_out       r_res1;

    logic [31:0] cur_p [3];
    logic [31:0] cur_v [3];
    logic [32:0] dp_mag;
    logic [32:0] dv_mag;
    logic        first;
    logic        sev_now;
    logic [RW-1:0] acc_sh;
    logic [30:0] t_val;
    logic signed [31:0] f_sum [3];
    logic signed [31:0] f_low [3];

    always_comb begin
        cur_p[0] = r_item.pos_x;
        cur_p[1] = r_item.pos_y;
        cur_p[2] = r_item.pos_z;
        cur_v[0] = r_item.vel_x;
        cur_v[1] = r_item.vel_y;
        cur_v[2] = r_item.vel_z;
        dp_mag   = mag33(r_dp[r_c]);
        dv_mag   = mag33(r_dv[r_c]);
        first    = r_item.is_first || !r_have;
        sev_now  = i_cfg.sever_enable && (r_item.time_now >= i_cfg.cut_time);
        acc_sh   = r_acc >> FRAC_BITS;
        t_val    = (r_tsat || (|acc_sh[RW-1:31])) ? T_MAX : acc_sh[30:0];
        for (int c = 0; c < 3; c++) begin
            f_sum[c] = sat32(33'(r_pend_f[c]) + 33'(r_fup[c]));
            f_low[c] = -r_fup[c];
        end
    end

    // request to the shared unit
    always_comb begin
        o_req.start = 1'b0;
        o_req.op    = U_MUL;
        o_req.x     = '0;
        o_req.y     = '0;
        unique case (r_state)
            S_SQ: begin
                o_req.start = !r_wait;
                o_req.x     = XW'(dp_mag);
                o_req.y     = YW'(dp_mag);
            end
            S_DT: begin
                o_req.start = !r_wait;
                o_req.x     = XW'(dp_mag);
                o_req.y     = YW'(dv_mag);
            end
            S_ROOT: begin
                o_req.start = !r_wait;
                o_req.op    = U_SQRT;
                o_req.x     = r_s;
            end
            S_RATE: begin
                o_req.start = !r_wait;
                o_req.op    = U_DIV;
                o_req.x     = r_dot;
                o_req.y     = r_dist;
            end
            S_DAMP: begin
                o_req.start = !r_wait;
                o_req.x     = r_rate;
                o_req.y     = YW'(i_cfg.damping);
            end
            S_STIFF: begin
                o_req.start = !r_wait;
                o_req.x     = XW'(r_stretch);
                o_req.y     = YW'(i_cfg.stiffness);
            end
            S_FMUL: begin
                o_req.start = !r_wait;
                o_req.x     = XW'(dp_mag);
                o_req.y     = YW'(r_ten);
            end
            S_FDIV: begin
                o_req.start = !r_wait;
                o_req.op    = U_DIV;
                o_req.x     = r_num;
                o_req.y     = r_dist;
            end
            default: begin
                o_req.start = 1'b0;
            end
        endcase
    end

    // sequencer and chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wait     <= 1'b0;
            r_have     <= 1'b0;
            r_pend_ten <= '0;
            r_pend_top <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_prev_p[c] <= '0;
                r_prev_v[c] <= '0;
                r_pend_f[c] <= '0;
            end
        end else begin
            if (o_req.start) begin
                r_wait <= 1'b1;
            end
            if (i_rsp.done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_sev <= sev_now;
                    if (first) begin
                        if (r_item.is_final) begin
                            r_res0  <= '{force_x: '0, force_y: '0, force_z: '0,
                                         tension_above: '0, top_node: 1'b1,
                                         end_of_chain: 1'b1, severed: sev_now};
                            r_nres  <= 2'd1;
                            r_have  <= 1'b0;
                            r_pend_ten <= '0;
                            r_pend_top <= 1'b0;
                            for (int c = 0; c < 3; c++) begin
                                r_prev_p[c] <= '0;
                                r_prev_v[c] <= '0;
                                r_pend_f[c] <= '0;
                            end
                            r_state <= S_EMIT;
                        end else begin
                            for (int c = 0; c < 3; c++) begin
                                r_prev_p[c] <= cur_p[c];
                                r_prev_v[c] <= cur_v[c];
                                r_pend_f[c] <= '0;
                            end
                            r_pend_ten <= '0;
                            r_pend_top <= 1'b1;
                            r_have     <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        for (int c = 0; c < 3; c++) begin
                            r_dp[c]  <= 33'(signed'(r_prev_p[c])) - 33'(signed'(cur_p[c]));
                            r_dv[c]  <= 33'(signed'(r_prev_v[c])) - 33'(signed'(cur_v[c]));
                            r_fup[c] <= '0;
                        end
                        r_ten   <= '0;
                        r_s     <= '0;
                        r_dot   <= '0;
                        r_c     <= '0;
                        r_state <= sev_now ? S_FIN : S_SQ;
                    end
                end
                // sum of squared differences
                S_SQ: begin
                    if (i_rsp.done) begin
                        r_s <= r_s + i_rsp.res[XW-1:0];
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_DT;
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                // signed dot product of position and velocity differences
                S_DT: begin
                    if (i_rsp.done) begin
                        if (r_dp[r_c][32] != r_dv[r_c][32]) begin
                            r_dot <= r_dot - signed'(i_rsp.res[XW-1:0]);
                        end else begin
                            r_dot <= r_dot + signed'(i_rsp.res[XW-1:0]);
                        end
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_ROOT;
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                S_ROOT: begin
                    if (i_rsp.done) begin
                        r_dist  <= i_rsp.res[YW-1:0];
                        r_state <= S_CHK;
                    end
                end
                // slack, short or unstretched segments pull nothing
                S_CHK: begin
                    r_tsat    <= 1'b0;
                    r_stretch <= r_dist - YW'(i_cfg.rest_length);
                    if ((r_dist < YW'(i_cfg.min_distance)) ||
                        (r_dist <= YW'(i_cfg.rest_length))) begin
                        r_state <= S_FIN;
                    end else if (!r_dot[XW-1] && (|r_dot)) begin
                        r_state <= S_RATE;
                    end else begin
                        r_acc   <= '0;
                        r_state <= S_STIFF;
                    end
                end
                // lengthening rate, saturated early when damping dominates
                S_RATE: begin
                    if (i_rsp.done) begin
                        if (i_cfg.damping == '0) begin
                            r_acc   <= '0;
                            r_state <= S_STIFF;
                        end else if (|i_rsp.res[XW-1:SAT_SH]) begin
                            r_tsat  <= 1'b1;
                            r_state <= S_TEN;
                        end else begin
                            r_rate  <= i_rsp.res[XW-1:0];
                            r_state <= S_DAMP;
                        end
                    end
                end
                S_DAMP: begin
                    if (i_rsp.done) begin
                        r_acc   <= i_rsp.res;
                        r_state <= S_STIFF;
                    end
                end
                S_STIFF: begin
                    if (i_rsp.done) begin
                        r_acc   <= r_acc + i_rsp.res;
                        r_state <= S_TEN;
                    end
                end
                S_TEN: begin
                    r_c <= '0;
                    if (t_val == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ten   <= t_val;
                        r_state <= S_FMUL;
                    end
                end
                // per axis force: tension times difference over distance
                S_FMUL: begin
                    if (i_rsp.done) begin
                        r_num   <= i_rsp.res[XW-1:0];
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (i_rsp.done) begin
                        if (!r_dp[r_c][32] && (|r_dp[r_c])) begin
                            r_fup[r_c] <= -signed'({1'b0, i_rsp.res[30:0]});
                        end else begin
                            r_fup[r_c] <= signed'({1'b0, i_rsp.res[30:0]});
                        end
                        if (r_c == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_state <= S_FMUL;
                        end
                    end
                end
                // build results and advance the chain
                S_FIN: begin
                    r_res0.force_x       <= r_sev ? '0 : f_sum[0];
                    r_res0.force_y       <= r_sev ? '0 : f_sum[1];
                    r_res0.force_z       <= r_sev ? '0 : f_sum[2];
                    r_res0.tension_above <= r_sev ? '0 : r_pend_ten;
                    r_res0.top_node      <= r_pend_top;
                    r_res0.end_of_chain  <= 1'b0;
                    r_res0.severed       <= r_sev;
                    r_res1.force_x       <= r_sev ? '0 : f_low[0];
                    r_res1.force_y       <= r_sev ? '0 : f_low[1];
                    r_res1.force_z       <= r_sev ? '0 : f_low[2];
                    r_res1.tension_above <= r_sev ? '0 : r_ten;
                    r_res1.top_node      <= 1'b0;
                    r_res1.end_of_chain  <= 1'b1;
                    r_res1.severed       <= r_sev;
                    if (r_item.is_final) begin
                        r_nres     <= 2'd2;
                        r_have     <= 1'b0;
                        r_pend_ten <= '0;
                        r_pend_top <= 1'b0;
                        for (int c = 0; c < 3; c++) begin
                            r_prev_p[c] <= '0;
                            r_prev_v[c] <= '0;
                            r_pend_f[c] <= '0;
                        end
                    end else begin
                        r_nres     <= 2'd1;
                        r_have     <= 1'b1;
                        r_pend_ten <= r_ten;
                        r_pend_top <= 1'b0;
                        for (int c = 0; c < 3; c++) begin
                            r_prev_p[c] <= cur_p[c];
                            r_prev_v[c] <= cur_v[c];
                            r_pend_f[c] <= f_low[c];
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_emit = (r_state == S_EMIT) && i_room;
    assign o_nres = r_nres;
    assign o_res0 = r_res0;
    assign o_res1 = r_res1;

endmodule

FILE: rtl/rope_chain_spring_force_top.sv
// Tension-only spring-damper force for a rope chain, one node per request.
// Input channel: i_in_valid / o_in_stall carry one node (time, position,
// velocity, top/bottom flags); a request is taken when valid is high and
// stall is low. Nodes come from the top of the rope to the bottom.
// Output channel: o_out_valid / i_out_stall carry net node forces. A node's
// result is sent once the segment below it is known, so a middle node gives
// one result (for the node above), the bottom node two, a top node none and
// a single-node chain one.
// Configuration: i_cfg_valid / o_cfg_ready write the six rope registers by
// index; write only while the block is idle.
// Work per node: a top node goes from decode straight back to idle, a
// severed node passes only decode, finish and emit. A segment runs six
// multiplies and a root on one shared bit-serial unit (34 steps per multiply
// or root, 68 per divide); a stretched one adds a stiffness multiply, a
// rate divide and damping multiply while lengthening, and three
// multiply-divide pairs.
// One node is in work at a time. Results sit in a two-entry output buffer;
// while the receiver stalls, the next node may still be taken and computed,
// and it waits to hand over its results until the buffer drains.
// Reset restores register defaults and closes any open chain.
module rope_chain_spring_force_top
    import rcsf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_out       r_ob [2];
    logic [1:0] r_ocnt;

    logic       core_busy;
    logic       core_emit;
    logic [1:0] core_nres;
    t_out       core_res0;
    t_out       core_res1;
    t_unit_req  unit_req;
    t_unit_rsp  unit_rsp;
    logic       out_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_length  <= RST_REST_LENGTH;
            r_cfg.stiffness    <= RST_STIFFNESS;
            r_cfg.damping      <= RST_DAMPING;
            r_cfg.min_distance <= RST_MIN_DISTANCE;
            r_cfg.sever_enable <= 1'b0;
            r_cfg.cut_time     <= RST_SEVER_TIME;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REST_LENGTH:  r_cfg.rest_length  <= i_cfg_data;
                CFG_STIFFNESS:    r_cfg.stiffness    <= i_cfg_data;
                CFG_DAMPING:      r_cfg.damping      <= i_cfg_data;
                CFG_MIN_DISTANCE: r_cfg.min_distance <= i_cfg_data;
                CFG_SEVER_ENABLE: r_cfg.sever_enable <= i_cfg_data[0];
                CFG_SEVER_TIME:   r_cfg.cut_time     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    rcsf_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid && !o_in_stall),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_busy  (core_busy),
        .i_room  (r_ocnt == 2'd0),
        .o_emit  (core_emit),
        .o_nres  (core_nres),
        .o_res0  (core_res0),
        .o_res1  (core_res1),
        .o_req   (unit_req),
        .i_rsp   (unit_rsp)
    );

    rcsf_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    assign o_in_stall = core_busy;

    // output buffer, loaded only when empty
    assign out_pop = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if (core_emit) begin
            r_ob[0] <= core_res0;
            r_ob[1] <= core_res1;
            r_ocnt  <= core_nres;
        end else if (out_pop) begin
            r_ob[0] <= r_ob[1];
            r_ocnt  <= r_ocnt - 2'd1;
        end
    end

    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_out       = r_ob[0];

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_emit |-> (r_ocnt == 2'd0))
        else $error("results loaded into a non-empty buffer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("output buffer count out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> core_busy)
        else $error("accepted request did not start the sequencer");

    a_sev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.severed) |-> (o_out.tension_above == '0))
        else $error("severed result carries tension");

endmodule

FILE: sim/rope_chain_spring_force_top_test.sv
`timescale 1ns / 100ps

module rope_chain_spring_force_top_test;
    import rcsf_pkg::*;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam logic [63:0] TEN_MAX = 64'h7FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    rope_chain_spring_force_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // rope registers as the block should hold them
    logic [31:0] rest_len, spring_k, damp_c, min_dist, sever_at;
    logic        sever_on;

    // open chain state
    logic signed [31:0] link_pos [3];
    logic signed [31:0] link_vel [3];
    logic signed [31:0] owed_force [3];
    logic [30:0]        owed_tension;
    logic               owed_top;
    logic               chain_open;

    t_out force_q[$];

    int  n_items = 0, n_results = 0, n_severed = 0, n_bad = 0, cycles = 0;
    bit  quiet = 1'b0;
    int  hold_left = 0;
    int  stall_burst = 0, stall_calm = 0, send_calm = 0;
    int  walk_pos [3];

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic close_chain();
        for (int c = 0; c < 3; c++) begin
            link_pos[c] = '0;
            link_vel[c] = '0;
            owed_force[c] = '0;
        end
        owed_tension = '0;
        owed_top = 1'b0;
        chain_open = 1'b0;
    endtask

    task automatic reset_rope_regs();
        rest_len = RST_REST_LENGTH;
        spring_k = RST_STIFFNESS;
        damp_c = RST_DAMPING;
        min_dist = RST_MIN_DISTANCE;
        sever_on = 1'b0;
        sever_at = RST_SEVER_TIME;
        close_chain();
    endtask

    // work out the node forces that one accepted node releases
    task automatic predict_node(input t_in it);
        logic signed [31:0] cur_p [3];
        logic signed [31:0] cur_v [3];
        logic signed [63:0] dp [3];
        logic signed [63:0] dv [3];
        logic signed [63:0] fup [3];
        logic signed [31:0] net [3];
        logic [63:0]  mdp [3];
        logic [63:0]  mdv [3];
        logic [127:0] sq, pp, nn, q, acc;
        logic [63:0]  seg_len, cand, stretch, rate, ten, f;
        logic         sev;
        t_out         r;
        sev = sever_on && (it.time_now >= sever_at);
        cur_p[0] = it.pos_x; cur_p[1] = it.pos_y; cur_p[2] = it.pos_z;
        cur_v[0] = it.vel_x; cur_v[1] = it.vel_y; cur_v[2] = it.vel_z;
        r = '0;
        // top node, lone node or a chain that starts without its top flag
        if (it.is_first || !chain_open) begin
            if (it.is_final) begin
                close_chain();
                r.top_node = 1'b1;
                r.end_of_chain = 1'b1;
                r.severed = sev;
                force_q = {force_q, r};
                return;
            end
            for (int c = 0; c < 3; c++) begin
                link_pos[c] = cur_p[c];
                link_vel[c] = cur_v[c];
                owed_force[c] = '0;
            end
            owed_tension = '0;
            owed_top = 1'b1;
            chain_open = 1'b1;
            return;
        end
        // segment geometry
        sq = '0; pp = '0; nn = '0;
        for (int c = 0; c < 3; c++) begin
            dp[c] = link_pos[c];
            dp[c] = dp[c] - cur_p[c];
            dv[c] = link_vel[c];
            dv[c] = dv[c] - cur_v[c];
            mdp[c] = dp[c] < 0 ? -dp[c] : dp[c];
            mdv[c] = dv[c] < 0 ? -dv[c] : dv[c];
            sq = sq + 128'(mdp[c]) * 128'(mdp[c]);
            if ((dp[c] < 0) != (dv[c] < 0)) nn = nn + 128'(mdp[c]) * 128'(mdv[c]);
            else pp = pp + 128'(mdp[c]) * 128'(mdv[c]);
            fup[c] = '0;
        end
        ten = '0;
        if (!sev) begin
            seg_len = '0;
            for (int b = 40; b >= 0; b--) begin
                cand = seg_len | (64'd1 << b);
                if (128'(cand) * 128'(cand) <= sq) seg_len = cand;
            end
            if (!(seg_len < 64'(min_dist) || seg_len <= 64'(rest_len))) begin
                stretch = seg_len - 64'(rest_len);
                rate = '0;
                // damping only while the segment lengthens
                if (nn < pp) begin
                    q = (pp - nn) / 128'(seg_len);
                    rate = (q[127:64] != 0) ? '1 : q[63:0];
                end
                acc = 128'(spring_k) * 128'(stretch);
                if (rate > 0) acc = acc + 128'(damp_c) * 128'(rate);
                acc = acc >> FRAC;
                ten = (acc > 128'(TEN_MAX)) ? TEN_MAX : acc[63:0];
                if (ten != 0) begin
                    for (int c = 0; c < 3; c++) begin
                        f = 64'((128'(ten) * 128'(mdp[c])) / 128'(seg_len));
                        fup[c] = dp[c] > 0 ? -$signed(f) : $signed(f);
                    end
                end
            end
        end
        // result owed to the node above
        for (int c = 0; c < 3; c++) net[c] = sev ? '0 : clamp32(owed_force[c] + fup[c]);
        r.force_x = net[0]; r.force_y = net[1]; r.force_z = net[2];
        r.tension_above = sev ? '0 : owed_tension;
        r.top_node = owed_top;
        r.severed = sev;
        force_q = {force_q, r};
        for (int c = 0; c < 3; c++) net[c] = sev ? '0 : clamp32(-fup[c]);
        if (it.is_final) begin
            r = '0;
            r.force_x = net[0]; r.force_y = net[1]; r.force_z = net[2];
            r.tension_above = sev ? '0 : ten[30:0];
            r.end_of_chain = 1'b1;
            r.severed = sev;
            force_q = {force_q, r};
            close_chain();
            return;
        end
        for (int c = 0; c < 3; c++) begin
            link_pos[c] = cur_p[c];
            link_vel[c] = cur_v[c];
            owed_force[c] = clamp32(-fup[c]);
        end
        owed_tension = ten[30:0];
        owed_top = 1'b0;
        chain_open = 1'b1;
    endtask

    // receiver: random stall bursts, calm stretches, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_burst > 0) begin
            stall_burst--;
            i_out_stall <= 1'b1;
        end else if (stall_calm > 0) begin
            stall_calm--;
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 2) == 0) stall_calm = $urandom_range(20, 300);
            else stall_burst = $urandom_range(1, 11);
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (o_out_valid && !i_out_stall) begin
            n_results++;
            if (o_out.severed) n_severed++;
            if (force_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %p", o_out);
            end else begin
                want = force_q.pop_front();
                if (o_out.force_x !== want.force_x || o_out.force_y !== want.force_y ||
                    o_out.force_z !== want.force_z ||
                    o_out.tension_above !== want.tension_above ||
                    o_out.top_node !== want.top_node ||
                    o_out.end_of_chain !== want.end_of_chain ||
                    o_out.severed !== want.severed) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %p, got %p", want, o_out);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, force_q.size());
            $display("rope_chain_spring_force_top_test: errors");
            $finish;
        end
    end

    // send one node request, with random gaps in front of it
    task automatic send_node(input t_in it);
        int gap;
        gap = 0;
        if (!quiet) begin
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(10, 60);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_node(it);
        n_items++;
    endtask

    task automatic end_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put(input bit first, input bit fin, input logic [31:0] tm,
                       input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] pz, input logic [31:0] vx,
                       input logic [31:0] vy, input logic [31:0] vz);
        t_in it;
        it.time_now = tm;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
        it.is_first = first;
        it.is_final = fin;
        send_node(it);
    endtask

    // wait until all results are in and the block has settled
    task automatic wait_drained();
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_REST_LENGTH:  rest_len = val;
            CFG_STIFFNESS:    spring_k = val;
            CFG_DAMPING:      damp_c = val;
            CFG_MIN_DISTANCE: min_dist = val;
            CFG_SEVER_ENABLE: sever_on = val[0];
            CFG_SEVER_TIME:   sever_at = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] rl, input logic [31:0] k,
                             input logic [31:0] d, input logic [31:0] md,
                             input logic sen, input logic [31:0] st);
        wait_drained();
        write_reg(CFG_REST_LENGTH, rl);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_DAMPING, d);
        write_reg(CFG_MIN_DISTANCE, md);
        write_reg(CFG_SEVER_ENABLE, {31'd0, sen});
        write_reg(CFG_SEVER_TIME, st);
    endtask

    // next node of a hanging rope: a short random step from the one above,
    // or fully random content when wild
    function automatic t_in rope_node(input bit first, input bit fin, input bit wild);
        t_in it;
        int  p [3];
        int  v [3];
        for (int c = 0; c < 3; c++) begin
            if (wild) begin
                p[c] = $urandom;
                v[c] = $urandom;
            end else begin
                if (first) p[c] = int'($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
                else p[c] = walk_pos[c] + int'($urandom_range(0, 6 * 65536)) - 3 * 65536;
                v[c] = int'($urandom_range(0, 10 * 65536)) - 5 * 65536;
            end
            walk_pos[c] = p[c];
        end
        it.time_now = $urandom;
        it.pos_x = p[0]; it.pos_y = p[1]; it.pos_z = p[2];
        it.vel_x = v[0]; it.vel_y = v[1]; it.vel_z = v[2];
        it.is_first = first;
        it.is_final = fin;
        return it;
    endfunction

    task automatic send_chain(input int len, input int wild_pct);
        for (int i = 0; i < len; i++)
            send_node(rope_node(i == 0, i == len - 1, $urandom_range(0, 99) < wild_pct));
    endtask

    // single node, stretched and slack pairs, extremes, restart, missing top
    task automatic test_directed();
        put(1, 1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(1, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        put(0, 1, 32'h0, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0);
        put(1, 0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(0, 1, 32'h0, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        put(0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        put(0, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0,
            32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        put(1, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(1, 0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(0, 1, 32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000);
        put(0, 0, 32'h0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(0, 1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        put(1, 0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        put(0, 1, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        put(1, 0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put(0, 1, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h0, 32'h0, 32'h0);
        end_sending();
    endtask

    // register settings: extremes, saturation, sever on and off
    task automatic test_config();
        write_all('0, '0, '0, '0, 1'b0, '0);
        repeat (3) send_chain($urandom_range(2, 4), 20);
        end_sending();
        write_all('1, '1, '1, '1, 1'b1, '1);
        repeat (3) send_chain($urandom_range(2, 4), 50);
        end_sending();
        write_all('0, '1, '1, '0, 1'b0, '0);
        repeat (3) send_chain($urandom_range(2, 4), 30);
        end_sending();
        write_all(32'h0000_8000, 32'h0100_0000, 32'h0004_0000, 32'h0010_0000,
                  1'b1, 32'h8000_0000);
        repeat (4) send_chain($urandom_range(2, 4), 20);
        end_sending();
        write_all(RST_REST_LENGTH, RST_STIFFNESS, RST_DAMPING, RST_MIN_DISTANCE,
                  1'b1, '0);
        repeat (2) send_chain($urandom_range(2, 4), 10);
        end_sending();
        write_all(RST_REST_LENGTH, RST_STIFFNESS, RST_DAMPING, RST_MIN_DISTANCE,
                  1'b0, RST_SEVER_TIME);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        wait_drained();
        hold_left = 4000;
        send_chain(12, 10);
        end_sending();
        wait_drained();
    endtask

    // sender pauses until every owed result is in
    task automatic test_pause();
        send_chain(3, 0);
        end_sending();
        while (force_q.size() != 0) @(posedge i_clk);
        send_chain(4, 0);
        end_sending();
    endtask

    // mostly well-formed chains, some noise, random register settings
    task automatic test_random();
        int target;
        int since_cfg;
        target = n_items + 640;
        since_cfg = 0;
        while (n_items < target) begin
            if (since_cfg > 150 && target - n_items > 120) begin
                end_sending();
                write_all($urandom_range(0, 3 * 65536), $urandom, $urandom,
                          $urandom_range(0, 4 * 65536), 1'($urandom_range(0, 1)),
                          $urandom);
                since_cfg = 0;
            end
            if (target - n_items < 100) quiet = 1'b1;
            if ($urandom_range(0, 9) < 8) begin
                send_chain($urandom_range(1, 5), 12);
            end else begin
                send_node(rope_node(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'b1));
            end
            since_cfg = n_items - (target - 640) > 0 ? since_cfg + 1 : since_cfg;
        end
        end_sending();
    endtask

    initial begin
        reset_rope_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_backpressure();
        test_pause();
        test_random();
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d nodes over directed, register, hold-off and random phases;",
                 n_items);
        $display("checked %0d node forces (%0d severed), %0d mismatches",
                 n_results, n_severed, n_bad);
        if (n_bad == 0 && force_q.size() == 0) begin
            $display("rope_chain_spring_force_top_test: clean");
        end else begin
            $display("rope_chain_spring_force_top_test: errors");
        end
        $finish;
    end

endmodule
